// ===== design/sts_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sts_pkg: shared types and constants of the script token scanner
// Token kinds, character codes, the keyword table and the transfer structs.
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam int OUT_BITS    = 16;
    localparam int KIND_BITS   = 6;
    localparam int KW_CHARS    = 6;
    localparam int KW_COUNT    = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int LEVEL_BITS  = 3;
    localparam int PTR_BITS    = 2;
    localparam int BURST_MAX   = 3;

    localparam logic [15:0] LINE_TOP = 16'hFFFF;

    // token kinds
    localparam logic [KIND_BITS-1:0] KIND_LPAREN     = 6'd0;
    localparam logic [KIND_BITS-1:0] KIND_RPAREN     = 6'd1;
    localparam logic [KIND_BITS-1:0] KIND_LBRACE     = 6'd2;
    localparam logic [KIND_BITS-1:0] KIND_RBRACE     = 6'd3;
    localparam logic [KIND_BITS-1:0] KIND_COMMA      = 6'd4;
    localparam logic [KIND_BITS-1:0] KIND_DOT        = 6'd5;
    localparam logic [KIND_BITS-1:0] KIND_MINUS      = 6'd6;
    localparam logic [KIND_BITS-1:0] KIND_PLUS       = 6'd7;
    localparam logic [KIND_BITS-1:0] KIND_SEMI       = 6'd8;
    localparam logic [KIND_BITS-1:0] KIND_STAR       = 6'd9;
    localparam logic [KIND_BITS-1:0] KIND_BANG       = 6'd10;
    localparam logic [KIND_BITS-1:0] KIND_SLASH      = 6'd18;
    localparam logic [KIND_BITS-1:0] KIND_IDENT      = 6'd19;
    localparam logic [KIND_BITS-1:0] KIND_STRING     = 6'd20;
    localparam logic [KIND_BITS-1:0] KIND_NUMBER     = 6'd21;
    localparam logic [KIND_BITS-1:0] KIND_KW0        = 6'd22;
    localparam logic [KIND_BITS-1:0] KIND_UNEXPECTED = 6'd38;
    localparam logic [KIND_BITS-1:0] KIND_UNTERM     = 6'd39;
    localparam logic [KIND_BITS-1:0] KIND_END        = 6'd40;

    // character codes
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LESS    = 8'h3C;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_GREATER = 8'h3E;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;

    typedef struct packed {
        logic       op;
        logic [7:0] ch;
    } t_sts_in;

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic [OUT_BITS-1:0]  start_pos;
        logic [OUT_BITS-1:0]  span_len;
        logic [OUT_BITS-1:0]  line_no;
        logic                 run_end;
    } t_sts_tok;

    // tokens produced by one input transfer, first cnt entries valid
    typedef struct packed {
        logic [1:0]                   cnt;
        t_sts_tok [BURST_MAX-1:0]     tok;
    } t_sts_push;

    typedef struct packed {
        logic                  has_room;
        logic [LEVEL_BITS-1:0] level;
    } t_sts_qstat;

    typedef struct packed {
        logic [8*KW_CHARS-1:0] text;   // first character in the top byte
        logic [2:0]            len;
    } t_kw_entry;

    function automatic logic is_digit(input logic [7:0] ch);
        return ch inside {[CH_DIGIT_0:CH_DIGIT_9]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] ch);
        return ch inside {[CH_LOWER_A:CH_LOWER_Z], [CH_UPPER_A:CH_UPPER_Z], CH_UNDER};
    endfunction

    function automatic t_kw_entry kw_entry(input logic [3:0] idx);
        t_kw_entry e;
        case (idx)
            4'd0:    e = '{{"and",    24'h0}, 3'd3};
            4'd1:    e = '{{"class",   8'h0}, 3'd5};
            4'd2:    e = '{{"else",   16'h0}, 3'd4};
            4'd3:    e = '{{"false",   8'h0}, 3'd5};
            4'd4:    e = '{{"for",    24'h0}, 3'd3};
            4'd5:    e = '{{"fun",    24'h0}, 3'd3};
            4'd6:    e = '{{"if",     32'h0}, 3'd2};
            4'd7:    e = '{{"nil",    24'h0}, 3'd3};
            4'd8:    e = '{{"or",     32'h0}, 3'd2};
            4'd9:    e = '{{"print",   8'h0}, 3'd5};
            4'd10:   e = '{"return",          3'd6};
            4'd11:   e = '{{"super",   8'h0}, 3'd5};
            4'd12:   e = '{{"this",   16'h0}, 3'd4};
            4'd13:   e = '{{"true",   16'h0}, 3'd4};
            4'd14:   e = '{{"var",    24'h0}, 3'd3};
            default: e = '{{"while",   8'h0}, 3'd5};
        endcase
        return e;
    endfunction

    // word holds the first KW_CHARS bytes, first byte on top; len <= KW_CHARS
    function automatic logic [KIND_BITS-1:0] kw_lookup(input logic [8*KW_CHARS-1:0] word,
                                                       input logic [2:0] len);
        logic [KIND_BITS-1:0] kind;
        t_kw_entry            e;
        logic                 hit;
        kind = KIND_IDENT;
        for (int k = 0; k < KW_COUNT; k++) begin
            e   = kw_entry(4'(k));
            hit = (e.len == len);
            for (int i = 0; i < KW_CHARS; i++) begin
                if (i < int'(len) && word[8*KW_CHARS-1-8*i -: 8] != e.text[8*KW_CHARS-1-8*i -: 8])
                    hit = 1'b0;
            end
            if (hit) kind = KIND_KW0 + KIND_BITS'(k);
        end
        return kind;
    endfunction

endpackage
`default_nettype wire

// ===== design/sts_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sts_queue: token result queue
// Takes up to three tokens per cycle, hands out one per output transfer.
// ----------------------------------------------------------------------------
module sts_queue
    import sts_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_sts_push  i_push,
    input  wire logic       i_pop,
    output t_sts_tok        o_head,
    output t_sts_qstat      o_stat
);

    t_sts_tok              r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   r_wr;
    logic [PTR_BITS-1:0]   r_rd;
    logic [LEVEL_BITS-1:0] r_level;
    logic                  pop;

    assign pop = i_pop && (r_level != '0);

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < BURST_MAX; k++) begin
            if (2'(k) < i_push.cnt) r_mem[PTR_BITS'(r_wr + PTR_BITS'(k))] <= i_push.tok[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            r_wr    <= r_wr + PTR_BITS'(i_push.cnt);
            r_rd    <= r_rd + PTR_BITS'(pop);
            r_level <= r_level + LEVEL_BITS'(i_push.cnt) - LEVEL_BITS'(pop);
        end
    end

    assign o_head          = r_mem[r_rd];
    assign o_stat.level    = r_level;
    // a whole burst must fit before the next input transfer is taken
    assign o_stat.has_room = (r_level <= LEVEL_BITS'(QUEUE_DEPTH - BURST_MAX));

endmodule
`default_nettype wire

// ===== design/sts_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sts_core: scanner state and token decode
// Holds the scan mode and positions; turns one byte into up to three tokens.
// ----------------------------------------------------------------------------
module sts_core
    import sts_pkg::*;
#(
    parameter int POS_BITS    = 16,
    parameter int KEYWORD_MAX = 6
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_accept,
    input  wire t_sts_in  i_item,
    output t_sts_push     o_push
);

    localparam int WL_BITS = $clog2(KEYWORD_MAX + 2);
    localparam int WI_BITS = $clog2(KEYWORD_MAX);
    localparam logic [WL_BITS-1:0]  WL_MAX  = WL_BITS'(KEYWORD_MAX);
    localparam logic [WL_BITS-1:0]  WL_OVER = WL_BITS'(KEYWORD_MAX + 1);
    localparam logic [POS_BITS-1:0] POS_TOP = '1;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_INT, M_DOT, M_FRAC, M_STRING, M_SLASH, M_COMMENT, M_OP
    } t_mode;

    t_mode               r_mode,  n_mode;
    logic [1:0]          r_pend,  n_pend;
    logic [POS_BITS-1:0] r_start, n_start;
    logic [POS_BITS-1:0] r_pos,   n_pos;
    logic [15:0]         r_line,  n_line;
    logic [WL_BITS-1:0]  r_wlen,  n_wlen;
    logic [7:0]          r_wbuf [KEYWORD_MAX];

    logic                  wr_en;
    logic [WI_BITS-1:0]    wr_idx;
    logic [POS_BITS-1:0]   nxt;
    logic [POS_BITS-1:0]   dot_at;
    logic [15:0]           line_inc;
    logic [8*KW_CHARS-1:0] word;
    logic [KIND_BITS-1:0]  wkind;
    logic [KIND_BITS-1:0]  op_kind;
    t_sts_tok              fl0, fl1, ex;
    logic [1:0]            fl_cnt, fl_n, total;
    logic                  use_flush, ex_v, done;
    t_sts_tok [BURST_MAX-1:0] toks;
    logic [7:0]            ch;

    function automatic t_sts_tok mk_tok(input logic [KIND_BITS-1:0] kind,
                                        input logic [POS_BITS-1:0]  s,
                                        input logic [POS_BITS-1:0]  e,
                                        input logic [15:0]          line);
        t_sts_tok            t;
        logic [POS_BITS-1:0] d;
        d           = (e >= s) ? e - s : '0;
        t.kind      = kind;
        t.start_pos = OUT_BITS'(s);
        t.span_len  = OUT_BITS'(d);
        t.line_no   = line;
        t.run_end   = 1'b0;
        return t;
    endfunction

    assign ch       = i_item.ch;
    assign nxt      = (r_pos == POS_TOP) ? r_pos : r_pos + 1'b1;
    assign dot_at   = (r_pos > r_start) ? r_pos - 1'b1 : r_pos;
    assign line_inc = (r_line != LINE_TOP) ? r_line + 1'b1 : r_line;
    assign op_kind  = KIND_BANG + {3'b000, r_pend, 1'b0};

    always_comb begin
        for (int i = 0; i < KW_CHARS; i++) word[8*KW_CHARS-1-8*i -: 8] = r_wbuf[i];
        if (r_wlen > WL_BITS'(KW_CHARS)) wkind = KIND_IDENT;
        else                             wkind = kw_lookup(word, 3'(r_wlen));
    end

    // tokens that the pending mode completes when the current byte ends it
    always_comb begin
        fl_cnt = 2'd0;
        fl0    = '0;
        fl1    = '0;
        case (r_mode)
            M_IDENT: begin
                fl_cnt = 2'd1;
                fl0    = mk_tok(wkind, r_start, r_pos, r_line);
            end
            M_INT, M_FRAC: begin
                fl_cnt = 2'd1;
                fl0    = mk_tok(KIND_NUMBER, r_start, r_pos, r_line);
            end
            M_DOT: begin
                fl_cnt = 2'd2;
                fl0    = mk_tok(KIND_NUMBER, r_start, dot_at, r_line);
                fl1    = mk_tok(KIND_DOT, dot_at, r_pos, r_line);
            end
            M_STRING: begin
                fl_cnt = 2'd1;
                fl0    = mk_tok(KIND_UNTERM, r_start, r_pos, r_line);
            end
            M_SLASH: begin
                fl_cnt = 2'd1;
                fl0    = mk_tok(KIND_SLASH, r_start, r_pos, r_line);
            end
            M_OP: begin
                fl_cnt = 2'd1;
                fl0    = mk_tok(op_kind, r_start, r_pos, r_line);
            end
            default: ;
        endcase
    end

    always_comb begin
        n_mode    = r_mode;
        n_pend    = r_pend;
        n_start   = r_start;
        n_pos     = r_pos;
        n_line    = r_line;
        n_wlen    = r_wlen;
        wr_en     = 1'b0;
        wr_idx    = '0;
        use_flush = 1'b0;
        ex_v      = 1'b0;
        ex        = '0;
        done      = 1'b0;
        if (i_item.op) begin
            use_flush = 1'b1;
            ex_v      = 1'b1;
            ex        = mk_tok(KIND_END, r_pos, r_pos, r_line);
            n_mode    = M_IDLE;
            n_pend    = '0;
            n_start   = '0;
            n_pos     = '0;
            n_line    = 16'd1;
            n_wlen    = '0;
        end else begin
            case (r_mode)
                M_IDENT: begin
                    if (is_alpha(ch) || is_digit(ch)) begin
                        done = 1'b1;
                        if (r_wlen < WL_MAX) begin
                            wr_en  = 1'b1;
                            wr_idx = WI_BITS'(r_wlen);
                            n_wlen = r_wlen + 1'b1;
                        end else begin
                            n_wlen = WL_OVER;
                        end
                    end
                end
                M_INT: begin
                    if (is_digit(ch)) begin
                        done = 1'b1;
                    end else if (ch == CH_DOT) begin
                        n_mode = M_DOT;
                        done   = 1'b1;
                    end
                end
                M_DOT: begin
                    if (is_digit(ch)) begin
                        n_mode = M_FRAC;
                        done   = 1'b1;
                    end
                end
                M_FRAC: begin
                    if (is_digit(ch)) done = 1'b1;
                end
                M_STRING: begin
                    done = 1'b1;
                    if (ch == CH_QUOTE) begin
                        ex_v   = 1'b1;
                        ex     = mk_tok(KIND_STRING, r_start, nxt, r_line);
                        n_mode = M_IDLE;
                    end else if (ch == CH_LF) begin
                        n_line = line_inc;
                    end
                end
                M_SLASH: begin
                    if (ch == CH_SLASH) begin
                        n_mode = M_COMMENT;
                        done   = 1'b1;
                    end
                end
                M_COMMENT: begin
                    if (ch != CH_LF) done = 1'b1;
                end
                M_OP: begin
                    if (ch == CH_EQUAL) begin
                        ex_v   = 1'b1;
                        ex     = mk_tok(op_kind + 1'b1, r_start, nxt, r_line);
                        n_mode = M_IDLE;
                        done   = 1'b1;
                    end
                end
                default: ;
            endcase

            if (!done) begin
                // byte ends the pending token and starts fresh from idle
                use_flush = 1'b1;
                n_mode    = M_IDLE;
                n_start   = r_pos;
                case (ch)
                    CH_LPAREN:  begin ex_v = 1'b1; ex = mk_tok(KIND_LPAREN, r_pos, nxt, r_line); end
                    CH_RPAREN:  begin ex_v = 1'b1; ex = mk_tok(KIND_RPAREN, r_pos, nxt, r_line); end
                    CH_LBRACE:  begin ex_v = 1'b1; ex = mk_tok(KIND_LBRACE, r_pos, nxt, r_line); end
                    CH_RBRACE:  begin ex_v = 1'b1; ex = mk_tok(KIND_RBRACE, r_pos, nxt, r_line); end
                    CH_COMMA:   begin ex_v = 1'b1; ex = mk_tok(KIND_COMMA, r_pos, nxt, r_line); end
                    CH_DOT:     begin ex_v = 1'b1; ex = mk_tok(KIND_DOT, r_pos, nxt, r_line); end
                    CH_MINUS:   begin ex_v = 1'b1; ex = mk_tok(KIND_MINUS, r_pos, nxt, r_line); end
                    CH_PLUS:    begin ex_v = 1'b1; ex = mk_tok(KIND_PLUS, r_pos, nxt, r_line); end
                    CH_SEMI:    begin ex_v = 1'b1; ex = mk_tok(KIND_SEMI, r_pos, nxt, r_line); end
                    CH_STAR:    begin ex_v = 1'b1; ex = mk_tok(KIND_STAR, r_pos, nxt, r_line); end
                    CH_BANG:    begin n_mode = M_OP; n_pend = 2'd0; end
                    CH_EQUAL:   begin n_mode = M_OP; n_pend = 2'd1; end
                    CH_LESS:    begin n_mode = M_OP; n_pend = 2'd2; end
                    CH_GREATER: begin n_mode = M_OP; n_pend = 2'd3; end
                    CH_SLASH:   n_mode = M_SLASH;
                    CH_SPACE, CH_CR, CH_TAB: ;
                    CH_LF:      n_line = line_inc;
                    CH_QUOTE:   n_mode = M_STRING;
                    default: begin
                        if (is_digit(ch)) begin
                            n_mode = M_INT;
                        end else if (is_alpha(ch)) begin
                            n_mode = M_IDENT;
                            wr_en  = 1'b1;
                            wr_idx = '0;
                            n_wlen = WL_BITS'(1);
                        end else begin
                            ex_v = 1'b1;
                            ex   = mk_tok(KIND_UNEXPECTED, r_pos, nxt, r_line);
                        end
                    end
                endcase
            end
            n_pos = nxt;
        end
    end

    // pack flushed tokens first, then the byte's own token
    always_comb begin
        fl_n    = use_flush ? fl_cnt : 2'd0;
        total   = fl_n + 2'(ex_v);
        toks[0] = (fl_n != 2'd0) ? fl0 : ex;
        toks[1] = (fl_n == 2'd2) ? fl1 : ex;
        toks[2] = ex;
        for (int i = 0; i < BURST_MAX; i++) toks[i].run_end = (2'(i) == total - 2'd1);
        o_push.cnt = i_accept ? total : 2'd0;
        o_push.tok = toks;
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && wr_en) r_wbuf[wr_idx] <= ch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_pend  <= '0;
            r_start <= '0;
            r_pos   <= '0;
            r_line  <= 16'd1;
            r_wlen  <= '0;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_pend  <= n_pend;
            r_start <= n_start;
            r_pos   <= n_pos;
            r_line  <= n_line;
            r_wlen  <= n_wlen;
        end
    end

endmodule
`default_nettype wire

// ===== design/script_token_scanner.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// script_token_scanner: streaming source scanner
// Usage:
//   Source bytes enter on the input channel, one per transfer (op = 0), and
//   op = 1 marks end of input: it flushes the pending token, emits an end
//   marker and rewinds position and line count for the next source.
//   Tokens leave on the output channel, one per transfer, with kind, start
//   offset, length and line; run_end marks the last token of an input item.
//   A token is registered in the result queue and can be taken from the
//   cycle after the byte that completes it. Throughput: one byte per cycle.
//   The result queue holds four tokens and takes a byte only while it can
//   absorb a full burst of three, so an item that produces two or three
//   tokens holds the input back while the queue drains.
//   Receiver stall: the queue fills and the input stalls; nothing is dropped.
//   Reset (synchronous, active low) empties the queue and returns the scanner
//   to idle at offset 0, line 1.
// ----------------------------------------------------------------------------
module script_token_scanner
    import sts_pkg::*;
#(
    parameter int POS_BITS    = 16,
    parameter int KEYWORD_MAX = 6
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_sts_in  i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_sts_tok      o_out_data
);

    logic       in_accept;
    t_sts_push  push;
    t_sts_qstat qstat;

    assign o_in_stall  = !qstat.has_room;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = (qstat.level != '0);

    sts_core #(
        .POS_BITS    (POS_BITS),
        .KEYWORD_MAX (KEYWORD_MAX)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_in_data),
        .o_push   (push)
    );

    sts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (o_out_valid && !i_out_stall),
        .o_head  (o_out_data),
        .o_stat  (qstat)
    );

`ifndef ASSERT_OFF
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        qstat.level <= LEVEL_BITS'(QUEUE_DEPTH))
        else $error("token queue over capacity");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_end_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in_data.op) |=> o_out_valid)
        else $error("end of input produced no token");

    a_no_push_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_accept |-> (push.cnt == 2'd0))
        else $error("tokens pushed without an input transfer");
`endif

endmodule
`default_nettype wire
